// File: src/log_record_time_window_scan_unit_assert.svh
// Assertion macros used by the checker file of the scan unit
`ifndef LOG_RECORD_TIME_WINDOW_SCAN_UNIT_ASSERT_SVH
`define LOG_RECORD_TIME_WINDOW_SCAN_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define LRTS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define LRTS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/lrts_pkg.sv
// Types, codes and calendar tables for the log record time window scan unit
`timescale 1ns / 1ps

package lrts_pkg;

	// scan status codes
	localparam logic [1:0] ST_SEARCHING = 2'd0;
	localparam logic [1:0] ST_MATCH     = 2'd1;
	localparam logic [1:0] ST_LIMIT     = 2'd2;
	localparam logic [1:0] ST_OVER      = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_TARGET_TIME    = 2'd0;
	localparam logic [1:0] CFG_WINDOW_SECONDS = 2'd1;
	localparam logic [1:0] CFG_SCAN_LIMIT     = 2'd2;

	localparam logic [15:0] WINDOW_RESET = 16'd540;
	localparam logic [7:0]  MARK_HIGH    = 8'hAA;
	localparam logic [7:0]  MARK_LOW     = 8'h55;
	localparam logic [7:0]  YEARS_RANGE  = 8'd100;

	typedef struct packed {
		logic        first_record;
		logic [23:0] record_address;
		logic [7:0]  marker_high;
		logic [7:0]  marker_low;
		logic [7:0]  stamp_year;
		logic [7:0]  stamp_month;
		logic [7:0]  stamp_day_byte;
		logic [7:0]  stamp_hour;
		logic [7:0]  stamp_minute;
		logic [7:0]  stamp_second;
	} rec_item_t;

	typedef struct packed {
		logic [1:0]  scan_status;
		logic [23:0] record_index;
		logic [23:0] match_address;
	} res_item_t;

	typedef struct packed {
		logic [1:0]  reg_index;
		logic [31:0] reg_data;
	} cfg_write_t;

	// length of month 1..12; zero for a month code that means nothing
	function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		unique case (month)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
			4'd2:                                       len = leap ? 5'd29 : 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

	// days in the year before the first of the month, common year
	function automatic logic [8:0] days_before(input logic [3:0] month);
		logic [8:0] d;
		unique case (month)
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

// File: src/lrts_chan_if.sv
// Valid/ready channel interface carrying one payload per transaction
`timescale 1ns / 1ps

interface lrts_chan_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: src/log_record_time_window_scan_unit.sv
// Log record time window scan: stamp to seconds, window match and search control
// Path: a record transaction loads stage one, then passes three more pipeline stages and
// the result register. Throughput: one record per cycle; the whole pipeline holds while
// a result waits, so a stalled output stops intake.
// Reset: clears valids, counter, sets search over, window 540, target and limit 0.
`timescale 1ns / 1ps

module log_record_time_window_scan_unit #(
	parameter int ADDR_BITS  = 24,
	parameter int COUNT_BITS = 24
) (
	input logic       clk,
	input logic       arst_n,
	lrts_chan_if.sink   rec,
	lrts_chan_if.source res,
	lrts_chan_if.sink   cfg
);

	localparam logic [23:0] AddrMask = 24'((64'd1 << ADDR_BITS) - 64'd1);
	localparam logic [31:0] CountMax = 32'((64'd1 << COUNT_BITS) - 64'd1);

	// configuration registers
	logic [31:0] target_q;
	logic [15:0] window_q;
	logic [23:0] limit_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			window_q <= lrts_pkg::WINDOW_RESET;
			limit_q  <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.data.reg_index)
				lrts_pkg::CFG_TARGET_TIME:    target_q <= cfg.data.reg_data;
				lrts_pkg::CFG_WINDOW_SECONDS: window_q <= cfg.data.reg_data[15:0];
				lrts_pkg::CFG_SCAN_LIMIT:     limit_q  <= cfg.data.reg_data[23:0];
				default: ;
			endcase
		end
	end

	// every stage moves together whenever the result register can take a value
	logic res_valid_q;
	logic en;

	assign en        = !res_valid_q || res.ready;
	assign rec.ready = en;

	// stage 1: record register
	logic                v_s1;
	lrts_pkg::rec_item_t d_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= rec.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && rec.valid) begin
			d_s1 <= rec.data;
		end
	end

	// stage 2: calendar check, day count and time of day
	logic        leap;
	logic [6:0]  yr7;
	logic [3:0]  mo4;
	logic [4:0]  dy;
	logic [4:0]  mlen;
	logic        stamp_ok;
	logic [15:0] days_c;
	logic [16:0] tod_c;

	always_comb begin
		yr7  = d_s1.stamp_year[6:0];
		mo4  = d_s1.stamp_month[3:0];
		dy   = d_s1.stamp_day_byte[4:0];
		leap = (d_s1.stamp_year[1:0] == 2'd0);
		mlen = lrts_pkg::month_days(mo4, leap);
		stamp_ok = (d_s1.stamp_year < lrts_pkg::YEARS_RANGE)
			&& (d_s1.stamp_month >= 8'd1) && (d_s1.stamp_month <= 8'd12)
			&& (d_s1.stamp_hour <= 8'd23) && (d_s1.stamp_minute <= 8'd59)
			&& (d_s1.stamp_second <= 8'd59)
			&& (dy != 5'd0) && (dy <= mlen);
		days_c = 16'(yr7) * 16'd365
			+ 16'((8'(yr7) + 8'd3) >> 2)
			+ 16'(lrts_pkg::days_before(mo4))
			+ 16'(dy) - 16'd1
			+ 16'(leap && (mo4 > 4'd2));
		tod_c = 17'(d_s1.stamp_hour[4:0]) * 17'd3600
			+ 17'(d_s1.stamp_minute[5:0]) * 17'd60
			+ 17'(d_s1.stamp_second[5:0]);
	end

	logic        v_s2;
	logic        first_s2;
	logic [23:0] addr_s2;
	logic        marked_s2;
	logic        ok_s2;
	logic [15:0] days_s2;
	logic [16:0] tod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s1) begin
			first_s2  <= d_s1.first_record;
			addr_s2   <= d_s1.record_address & AddrMask;
			marked_s2 <= (d_s1.marker_high == lrts_pkg::MARK_HIGH)
				&& (d_s1.marker_low == lrts_pkg::MARK_LOW);
			ok_s2     <= stamp_ok;
			days_s2   <= days_c;
			tod_s2    <= tod_c;
		end
	end

	// stage 3: seconds since the epoch
	logic        v_s3;
	logic        first_s3;
	logic [23:0] addr_s3;
	logic        cand_s3;
	logic [31:0] secs_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s2) begin
			first_s3 <= first_s2;
			addr_s3  <= addr_s2;
			cand_s3  <= marked_s2 && ok_s2;
			secs_s3  <= 32'(days_s2) * 32'd86400 + 32'(tod_s2);
		end
	end

	// stage 4: window compare
	logic [31:0] diff_c;

	assign diff_c = (secs_s3 >= target_q) ? (secs_s3 - target_q) : (target_q - secs_s3);

	logic        v_s4;
	logic        first_s4;
	logic [23:0] addr_s4;
	logic        hit_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s3) begin
			first_s4 <= first_s3;
			addr_s4  <= addr_s3;
			hit_s4   <= cand_s3 && (diff_c <= 32'(window_q));
		end
	end

	// search control and result register
	logic [COUNT_BITS-1:0] cnt_q;
	logic                  done_q;
	logic [COUNT_BITS-1:0] cnt_eff;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic [COUNT_BITS-1:0] cnt_n;
	logic                  done_eff;
	logic                  done_n;
	logic [31:0]           limit32;
	logic [31:0]           idx32;
	logic [1:0]            status_c;
	logic [23:0]           maddr_c;

	always_comb begin
		cnt_eff  = first_s4 ? '0 : cnt_q;
		done_eff = first_s4 ? 1'b0 : done_q;
		cnt_inc  = cnt_eff + 1'b1;
		idx32    = 32'(cnt_eff);
		limit32  = (32'(limit_q) > CountMax) ? CountMax : 32'(limit_q);
		cnt_n    = cnt_eff;
		done_n   = 1'b1;
		maddr_c  = '0;
		priority if (done_eff) begin
			status_c = lrts_pkg::ST_OVER;
		end else if (idx32 >= limit32) begin
			// nothing left to examine: record is skipped
			status_c = lrts_pkg::ST_LIMIT;
		end else if (hit_s4) begin
			status_c = lrts_pkg::ST_MATCH;
			maddr_c  = addr_s4;
		end else begin
			cnt_n = cnt_inc;
			if (32'(cnt_inc) >= limit32) begin
				status_c = lrts_pkg::ST_LIMIT;
			end else begin
				status_c = lrts_pkg::ST_SEARCHING;
				done_n   = 1'b0;
			end
		end
	end

	lrts_pkg::res_item_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			cnt_q       <= '0;
			done_q      <= 1'b1;
		end else if (en) begin
			res_valid_q <= v_s4;
			if (v_s4) begin
				cnt_q  <= cnt_n;
				done_q <= done_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_s4) begin
			res_q.scan_status   <= status_c;
			res_q.record_index  <= idx32[23:0];
			res_q.match_address <= maddr_c;
		end
	end

	assign res.valid = res_valid_q;
	assign res.data  = res_q;

endmodule

// File: src/lrts_checker.sv
// Port-level checker for the scan unit, bound to the top level
`timescale 1ns / 1ps
`include "log_record_time_window_scan_unit_assert.svh"

module lrts_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                rec_valid,
	input logic                rec_ready,
	input logic                res_valid,
	input logic                res_ready,
	input lrts_pkg::res_item_t res_data
);

	// four pipeline stages plus the result register
	localparam logic [2:0] Depth = 3'd5;

	logic       rec_acc;
	logic       res_acc;
	logic [2:0] outstanding_q;

	assign rec_acc = rec_valid && rec_ready;
	assign res_acc = res_valid && res_ready;

	// records taken whose result transaction has not yet completed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outstanding_q <= '0;
		end else if (rec_acc && !res_acc) begin
			outstanding_q <= outstanding_q + 3'd1;
		end else if (res_acc && !rec_acc) begin
			outstanding_q <= outstanding_q - 3'd1;
		end
	end

	`LRTS_ASSERT_IMP(a_no_spurious_result, res_valid, outstanding_q != 3'd0, "result with no record in flight")
	`LRTS_ASSERT_IMP(a_in_flight_bound, 1'b1, outstanding_q <= Depth, "more records in flight than stages")
	`LRTS_ASSERT_IMP(a_addr_zero, res_valid && (res_data.scan_status != lrts_pkg::ST_MATCH), res_data.match_address == 24'd0, "address set without a match")
	`LRTS_ASSERT_NXT(a_result_hold, res_valid && !res_ready, res_valid && $stable(res_data), "stalled result changed")

endmodule

bind log_record_time_window_scan_unit lrts_checker u_lrts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rec_valid (rec.valid),
	.rec_ready (rec.ready),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_data  (res.data)
);
